@@ rtl/ajpd_pkg.sv @@
// ----------------------------------------------------------------------------
// ajpd_pkg
// Shared types and constants for the audio jack plug detector.
// ----------------------------------------------------------------------------
package ajpd_pkg;

    // Width of the window length register
    localparam int WINDOW_BITS = 10;

    // Window length after reset
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 10'd200;

    // Jack mode codes
    typedef enum logic [1:0] {
        MODE_ALL_DOWN      = 2'd0,
        MODE_BUZZER        = 2'd1,
        MODE_HEADPHONES    = 2'd2,
        MODE_BUZZER_SERIAL = 2'd3
    } jack_mode_t;

    // One result beat
    typedef struct packed {
        jack_mode_t jack_mode;
        logic       headphone_enable;
        logic       buzzer_enable;
        logic       power_enable;
        logic       probe_pull_up;
        logic       probe_power_pulse;
        logic       mode_changed;
    } ajpd_result_t;

endpackage

@@ rtl/audio_jack_plug_detector.sv @@
// An accepted tick goes through the input register, then the result register (m_valid);
// a stalled result (m_ready low) holds it back. Throughput: one tick per cycle while
// m_ready is high; input and result registers decouple the two sides.
// Reset (aresetn low, synchronous): mode all down, counters and flags cleared,
// window length 200, both registers empty.
// ----------------------------------------------------------------------------
// audio_jack_plug_detector
// Top level: tick input register, detection core, result register, window
// length register.
// ----------------------------------------------------------------------------
module audio_jack_plug_detector
    import ajpd_pkg::*;
#(
    parameter int COUNT_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // window length write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [WINDOW_BITS-1:0] cfg_window_ticks,
    // tick beats
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_sense_up_level,
    input  logic                   s_sense_down_level,
    input  logic                   s_sense_powered_level,
    input  logic                   s_mid_level,
    // result beats
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_jack_mode,
    output logic                   m_headphone_enable,
    output logic                   m_buzzer_enable,
    output logic                   m_power_enable,
    output logic                   m_probe_pull_up,
    output logic                   m_probe_power_pulse,
    output logic                   m_mode_changed
);

    logic [WINDOW_BITS-1:0] window_reg;
    logic                   in_valid_reg;
    logic [3:0]             in_data_reg;
    logic                   out_valid_reg;
    ajpd_result_t           out_data_reg;
    ajpd_result_t           core_result;
    logic                   advance;

    // Window length register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_valid) begin
            window_reg <= cfg_window_ticks;
        end
    end

    // Move a tick from input register to result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= {s_sense_up_level, s_sense_down_level,
                            s_sense_powered_level, s_mid_level};
        end
    end

    ajpd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .window_ticks        (window_reg),
        .step                (advance),
        .sense_up_level      (in_data_reg[3]),
        .sense_down_level    (in_data_reg[2]),
        .sense_powered_level (in_data_reg[1]),
        .mid_level           (in_data_reg[0]),
        .result              (core_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_jack_mode         = out_data_reg.jack_mode;
    assign m_headphone_enable  = out_data_reg.headphone_enable;
    assign m_buzzer_enable     = out_data_reg.buzzer_enable;
    assign m_power_enable      = out_data_reg.power_enable;
    assign m_probe_pull_up     = out_data_reg.probe_pull_up;
    assign m_probe_power_pulse = out_data_reg.probe_power_pulse;
    assign m_mode_changed      = out_data_reg.mode_changed;

    // Checks
    a_tick_held_while_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending tick dropped");

    a_result_held_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result lost");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not filled");

endmodule

@@ rtl/ajpd_core.sv @@
// ----------------------------------------------------------------------------
// ajpd_core
// Detection state and per-tick update: probing, counting, window decision.
// ----------------------------------------------------------------------------
module ajpd_core
    import ajpd_pkg::*;
#(
    parameter int COUNT_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [WINDOW_BITS-1:0] window_ticks,
    input  logic                   step,
    input  logic                   sense_up_level,
    input  logic                   sense_down_level,
    input  logic                   sense_powered_level,
    input  logic                   mid_level,
    output ajpd_result_t           result
);

    localparam int CMP_BITS = (COUNT_BITS > WINDOW_BITS) ? COUNT_BITS : WINDOW_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    jack_mode_t              mode_reg, mode_next;
    logic                    pull_up_reg, pull_up_next;
    logic                    prev_float_reg, prev_float_next;
    logic [COUNT_BITS-1:0]   tick_count_reg, tick_count_next;
    logic [COUNT_BITS-1:0]   low_count_reg, low_count_next;
    logic [COUNT_BITS-1:0]   forced_count_reg, forced_count_next;

    logic                    probe, pulse, used_up, level;
    logic [COUNT_BITS-1:0]   tick_inc, low_inc, forced_inc;
    logic                    win_end;
    jack_mode_t              decided;

    // Probe selection for this tick
    always_comb begin
        probe        = 1'b0;
        pulse        = 1'b0;
        used_up      = 1'b0;
        level        = 1'b0;
        pull_up_next = pull_up_reg;
        case (mode_reg)
            MODE_HEADPHONES: begin
                pull_up_next = ~pull_up_reg;
                used_up      = ~pull_up_reg;
                level        = used_up ? sense_up_level : sense_down_level;
                probe        = 1'b1;
            end
            MODE_ALL_DOWN, MODE_BUZZER: begin
                if (tick_count_reg == '0) begin
                    pull_up_next = 1'b0;
                    pulse        = 1'b1;
                    level        = sense_powered_level;
                    probe        = 1'b1;
                end
            end
            default: begin
                if (tick_count_reg == '0) begin
                    pull_up_next = 1'b0;
                    level        = sense_down_level;
                    probe        = 1'b1;
                end
            end
        endcase
    end

    // Saturating counters
    always_comb begin
        tick_inc   = (tick_count_reg == CNT_MAX) ? tick_count_reg
                                                 : tick_count_reg + 1'b1;
        forced_inc = forced_count_reg;
        if (probe && (level != used_up) && (forced_count_reg != CNT_MAX))
            forced_inc = forced_count_reg + 1'b1;
        low_inc = low_count_reg;
        if ((mode_reg != MODE_BUZZER_SERIAL) && !mid_level && (low_count_reg != CNT_MAX))
            low_inc = low_count_reg + 1'b1;
    end

    // Window end and mode decision
    always_comb begin
        win_end = (CMP_BITS'(tick_inc) >= CMP_BITS'(window_ticks)) || (tick_inc == CNT_MAX);
        decided = mode_reg;
        if (prev_float_reg)
            decided = (low_inc == tick_inc) ? MODE_HEADPHONES : MODE_BUZZER_SERIAL;
        else if (!((mode_reg == MODE_ALL_DOWN) && (forced_inc == '0)))
            decided = MODE_BUZZER;

        if (win_end) begin
            mode_next         = decided;
            prev_float_next   = (forced_inc == '0);
            tick_count_next   = '0;
            low_count_next    = '0;
            forced_count_next = '0;
        end else begin
            mode_next         = mode_reg;
            prev_float_next   = prev_float_reg;
            tick_count_next   = tick_inc;
            low_count_next    = low_inc;
            forced_count_next = forced_inc;
        end
    end

    // State registers, advanced once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_ALL_DOWN;
            pull_up_reg      <= 1'b0;
            prev_float_reg   <= 1'b0;
            tick_count_reg   <= '0;
            low_count_reg    <= '0;
            forced_count_reg <= '0;
        end else if (step) begin
            mode_reg         <= mode_next;
            pull_up_reg      <= pull_up_next;
            prev_float_reg   <= prev_float_next;
            tick_count_reg   <= tick_count_next;
            low_count_reg    <= low_count_next;
            forced_count_reg <= forced_count_next;
        end
    end

    // Result beat for this tick
    always_comb begin
        result.jack_mode         = mode_next;
        result.headphone_enable  = (mode_next == MODE_HEADPHONES);
        result.buzzer_enable     = (mode_next == MODE_BUZZER) ||
                                   (mode_next == MODE_BUZZER_SERIAL);
        result.power_enable      = (mode_next == MODE_BUZZER_SERIAL);
        result.probe_pull_up     = probe & used_up;
        result.probe_power_pulse = pulse;
        result.mode_changed      = (mode_next != mode_reg);
    end

    // Checks
    a_mode_only_at_window_end: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step && win_end) |=> $stable(mode_reg))
        else $error("mode changed outside a window end");

    a_low_within_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        low_count_reg <= tick_count_reg)
        else $error("low count ahead of tick count");

    a_forced_within_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        forced_count_reg <= tick_count_reg)
        else $error("forced count ahead of tick count");

    a_window_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        step && win_end |=> (tick_count_reg == '0) && (forced_count_reg == '0))
        else $error("counters not cleared at window end");

endmodule
